// File: rtl/leaky_adpcm_nibble_decoder_unit_defines.svh
// ---------------------------------------------------------------------------
// leaky_adpcm_nibble_decoder_unit_defines
// assertion macros shared by the decoder modules
// ---------------------------------------------------------------------------
`ifndef LEAKY_ADPCM_NIBBLE_DECODER_UNIT_DEFINES_SVH
`define LEAKY_ADPCM_NIBBLE_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LADPCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LADPCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ladpcm_pkg.sv
// ---------------------------------------------------------------------------
// ladpcm_pkg
// types, register indexes and step tables of the leaky adpcm decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ladpcm_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_STEREO_MODE       = 2'd0;
    localparam logic [1:0] CFG_HIGH_NIBBLE_FIRST = 2'd1;
    localparam logic [1:0] CFG_START_HISTORY     = 2'd2;
    localparam logic [1:0] CFG_START_STEP        = 2'd3;

    localparam logic [14:0] STEP_MIN = 15'd127;
    localparam logic [14:0] STEP_MAX = 15'd24576;

    // input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_beat_t;

    // output beat
    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               channel_id;
        logic               last_of_pair;
    } out_beat_t;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic               stereo_mode;
        logic               high_nibble_first;
        logic signed [15:0] start_history;
        logic [14:0]        start_step;
    } cfg_t;

    // classified byte waiting for the decoder
    typedef struct packed {
        logic [3:0] first_code;
        logic [3:0] second_code;
        logic       second_ch;
        logic       restart;
    } job_t;

    // step scale factor over 256, by code magnitude
    function automatic logic [9:0] step_scale(input logic [2:0] mag);
        logic [9:0] s;
        case (mag)
            3'd4:    s = 10'd307;
            3'd5:    s = 10'd409;
            3'd6:    s = 10'd512;
            3'd7:    s = 10'd614;
            default: s = 10'd230;
        endcase
        return s;
    endfunction

    // step clamp to 127..24576
    function automatic logic [14:0] clamp_step(input logic [16:0] s);
        logic [14:0] r;
        if (s < {2'b00, STEP_MIN})
        begin
            r = STEP_MIN;
        end
        else if (s > {2'b00, STEP_MAX})
        begin
            r = STEP_MAX;
        end
        else
        begin
            r = s[14:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/ladpcm_front.sv
// ---------------------------------------------------------------------------
// ladpcm_front
// accepts input beats, picks nibble order and channel, queues the jobs
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "leaky_adpcm_nibble_decoder_unit_defines.svh"

module ladpcm_front #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ladpcm_pkg::cfg_t     cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  ladpcm_pkg::in_beat_t in_data,
    output logic                job_valid,
    output ladpcm_pkg::job_t     job,
    input  logic                job_pop
);
    import ladpcm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             queue_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    job_t             job_new;
    logic             push;

    // classify the byte: nibble order and channel of the second sample
    always_comb
    begin
        if (cfg.high_nibble_first)
        begin
            job_new.first_code  = in_data.data_byte[7:4];
            job_new.second_code = in_data.data_byte[3:0];
        end
        else
        begin
            job_new.first_code  = in_data.data_byte[3:0];
            job_new.second_code = in_data.data_byte[7:4];
        end
        job_new.second_ch = cfg.stereo_mode;
        job_new.restart   = in_data.restart;
    end

    // handshake and queue bookkeeping
    assign in_ready  = (count_reg != FULL_CNT);
    assign push      = in_valid && in_ready;
    assign job_valid = (count_reg != '0);
    assign job       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (job_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(job_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= job_new;
        end
    end

    `LADPCM_ASSERT_NOW(a_pop_not_empty, job_pop, count_reg != '0, "pop from empty queue")
    `LADPCM_ASSERT_NEXT(a_count_up, push && !job_pop, count_reg == $past(count_reg) + 1'b1,
        "queue count did not follow a push")

endmodule

// File: rtl/ladpcm_back.sv
// ---------------------------------------------------------------------------
// ladpcm_back
// decodes a nibble a cycle unless stalled, with per-channel history and step
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "leaky_adpcm_nibble_decoder_unit_defines.svh"

module ladpcm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ladpcm_pkg::cfg_t      cfg,
    input  logic                 job_valid,
    input  ladpcm_pkg::job_t      job,
    output logic                 job_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ladpcm_pkg::out_beat_t out_data
);
    import ladpcm_pkg::*;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'b01,
        PH_SECOND = 2'b10
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic signed [15:0] hist_reg [2];
    logic [14:0]        step_reg [2];
    logic               out_valid_reg, out_valid_next;
    out_beat_t          out_reg;

    logic               fire;
    logic               last;
    logic               ch;
    logic [3:0]         code;
    logic               use_start;
    logic [14:0]        start_step_c;
    logic signed [15:0] h_cur;
    logic [14:0]        s_cur;
    logic signed [24:0] h_ext;
    logic signed [24:0] prod;
    logic signed [24:0] decay_wide;
    logic signed [17:0] decay;
    logic [18:0]        mag_wide;
    logic signed [17:0] mag;
    logic signed [17:0] sum;
    logic signed [15:0] sample;
    logic [24:0]        step_wide;
    logic [14:0]        step_new;

    // which nibble of the current job is up
    always_comb
    begin
        case (phase_reg)
            PH_FIRST:
            begin
                last = 1'b0;
                code = job.first_code;
                ch   = 1'b0;
            end
            PH_SECOND:
            begin
                last = 1'b1;
                code = job.second_code;
                ch   = job.second_ch;
            end
            default:
            begin
                last = 1'b0;
                code = job.first_code;
                ch   = 1'b0;
            end
        endcase
    end

    // restart takes its values from the registers on the first nibble
    assign start_step_c = clamp_step({2'b00, cfg.start_step});
    assign use_start    = job.restart && !last;
    assign h_cur        = use_start ? cfg.start_history : hist_reg[ch];
    assign s_cur        = use_start ? start_step_c : step_reg[ch];

    // history decay by 254/256, truncating toward zero
    always_comb
    begin
        h_ext      = 25'(h_cur);
        prod       = (h_ext <<< 8) - (h_ext <<< 1);
        decay_wide = (prod + (prod[24] ? 25'sd255 : 25'sd0)) >>> 8;
        decay      = decay_wide[17:0];
    end

    // odd multiple of step/8, sign from code bit 3, then saturate
    always_comb
    begin
        mag_wide = 19'(s_cur) * 19'({code[2:0], 1'b1});
        mag      = $signed({2'b00, mag_wide[18:3]});
        sum      = code[3] ? (decay - mag) : (decay + mag);
        if (sum > 18'sd32767)
        begin
            sample = 16'sh7fff;
        end
        else if (sum < -18'sd32768)
        begin
            sample = 16'sh8000;
        end
        else
        begin
            sample = sum[15:0];
        end
    end

    // step adaptation
    always_comb
    begin
        step_wide = 25'(s_cur) * 25'(step_scale(code[2:0]));
        step_new  = clamp_step(step_wide[24:8]);
    end

    // output register doubles as the skid between decoder and consumer
    assign fire    = job_valid && (!out_valid_reg || out_ready);
    assign job_pop = fire && last;

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            phase_next     = last ? PH_FIRST : PH_SECOND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            out_valid_reg <= 1'b0;
            hist_reg[0]   <= '0;
            hist_reg[1]   <= '0;
            step_reg[0]   <= STEP_MIN;
            step_reg[1]   <= STEP_MIN;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                // restart also loads channel 1, decoded channel wins
                if (use_start)
                begin
                    hist_reg[1] <= cfg.start_history;
                    step_reg[1] <= start_step_c;
                end
                hist_reg[ch] <= sample;
                step_reg[ch] <= step_new;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg.pcm_sample   <= sample;
            out_reg.channel_id   <= ch;
            out_reg.last_of_pair <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `LADPCM_ASSERT_NOW(a_second_has_job, phase_reg == PH_SECOND, job_valid,
        "second nibble pending without a queued job")
    `LADPCM_ASSERT_NOW(a_first_on_ch0, out_valid_reg && !out_reg.last_of_pair,
        !out_reg.channel_id, "first beat of a pair not on channel 0")
    `LADPCM_ASSERT_NOW(a_step_range, 1'b1,
        step_reg[0] >= STEP_MIN && step_reg[0] <= STEP_MAX &&
        step_reg[1] >= STEP_MIN && step_reg[1] <= STEP_MAX, "step left its range")

endmodule

// File: rtl/leaky_adpcm_nibble_decoder_unit.sv
// An accepted byte waits in the job queue; its two samples follow in order through the output
// register. Throughput: one output beat per cycle from the single nibble decode unit when the
// output is not stalled; the input side takes one byte per cycle until the job queue fills.
// Reset: registers go to mono, low nibble first, start history 0, start step 127;
// both channels to history 0 and step 127; queue and output empty.
// ---------------------------------------------------------------------------
// leaky_adpcm_nibble_decoder_unit
// top level: configuration registers, front classifier/queue, back decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module leaky_adpcm_nibble_decoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ladpcm_pkg::in_beat_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ladpcm_pkg::out_beat_t out_data
);
    import ladpcm_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic job_valid;
    job_t job;
    logic job_pop;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEREO_MODE:       cfg_next.stereo_mode       = cfg_data[0];
                CFG_HIGH_NIBBLE_FIRST: cfg_next.high_nibble_first = cfg_data[0];
                CFG_START_HISTORY:     cfg_next.start_history     = cfg_data;
                CFG_START_STEP:        cfg_next.start_step        = cfg_data[14:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stereo_mode       <= 1'b0;
            cfg_reg.high_nibble_first <= 1'b0;
            cfg_reg.start_history     <= '0;
            cfg_reg.start_step        <= STEP_MIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept and classify
    ladpcm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    // back: nibble decode and output beat
    ladpcm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: dv/adpcm_sample_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adpcm_sample_checker
// watches the register port and both beat channels of the leaky adpcm
// decoder, decodes every accepted byte with its own copy of the channel
// state and compares each sample beat with the oldest predicted sample
// ---------------------------------------------------------------------------

module adpcm_sample_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  ladpcm_pkg::in_beat_t  in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  ladpcm_pkg::out_beat_t out_data,
    output int                    mismatch_count,
    output int                    pending_count,
    output int                    out_beats_seen
);

    import ladpcm_pkg::*;

    // shadow registers and per-channel decoder state
    cfg_t               regs_shadow;
    logic signed [15:0] chan_history [2];
    logic [14:0]        chan_step [2];
    out_beat_t          predicted_samples [$];

    // step kept within 127..24576
    function automatic logic [14:0] limit_step(input int s);
        if (s < int'(STEP_MIN))
        begin
            return STEP_MIN;
        end
        if (s > int'(STEP_MAX))
        begin
            return STEP_MAX;
        end
        return s[14:0];
    endfunction

    // step growth factor over 256, by code magnitude
    function automatic int growth_of(input logic [2:0] mag);
        int g;
        case (mag)
            3'd4:    g = 307;
            3'd5:    g = 409;
            3'd6:    g = 512;
            3'd7:    g = 614;
            default: g = 230;
        endcase
        return g;
    endfunction

    // one nibble: leak the history, add the signed odd multiple, saturate, rescale step
    function automatic logic signed [15:0] decode_code(input logic ch, input logic [3:0] code);
        int h;
        int s;
        int mag;
        int val;
        h   = int'(chan_history[ch]);
        s   = int'(chan_step[ch]);
        h   = (h * 254) / 256;
        mag = (s * (2 * int'(code[2:0]) + 1)) / 8;
        val = code[3] ? h - mag : h + mag;
        if (val > 32767)
        begin
            val = 32767;
        end
        if (val < -32768)
        begin
            val = -32768;
        end
        chan_step[ch]    = limit_step((s * growth_of(code[2:0])) >> 8);
        chan_history[ch] = val[15:0];
        return val[15:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_beat_t  want;
        out_beat_t  first_s;
        out_beat_t  second_s;
        logic [3:0] code_a;
        logic [3:0] code_b;
        if (!rst_n)
        begin
            regs_shadow.stereo_mode       = 1'b0;
            regs_shadow.high_nibble_first = 1'b0;
            regs_shadow.start_history     = 16'sd0;
            regs_shadow.start_step        = 15'd127;
            chan_history[0] = 16'sd0;
            chan_history[1] = 16'sd0;
            chan_step[0]    = 15'd127;
            chan_step[1]    = 15'd127;
            predicted_samples.delete();
            mismatch_count = 0;
            pending_count  = 0;
            out_beats_seen = 0;
        end
        else
        begin
            // sample beat against the oldest prediction
            if (out_valid && out_ready)
            begin
                out_beats_seen++;
                if (predicted_samples.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected beat, expected none, actual %0d ch %0d last %0d",
                             $time, $signed(out_data.pcm_sample), out_data.channel_id,
                             out_data.last_of_pair);
                end
                else
                begin
                    want = predicted_samples.pop_front();
                    if (out_data.pcm_sample !== want.pcm_sample)
                    begin
                        mismatch_count++;
                        $display("%0t: pcm_sample expected %0d actual %0d", $time,
                                 $signed(want.pcm_sample), $signed(out_data.pcm_sample));
                    end
                    if (out_data.channel_id !== want.channel_id)
                    begin
                        mismatch_count++;
                        $display("%0t: channel_id expected %0d actual %0d", $time,
                                 want.channel_id, out_data.channel_id);
                    end
                    if (out_data.last_of_pair !== want.last_of_pair)
                    begin
                        mismatch_count++;
                        $display("%0t: last_of_pair expected %0d actual %0d", $time,
                                 want.last_of_pair, out_data.last_of_pair);
                    end
                end
            end

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STEREO_MODE:       regs_shadow.stereo_mode       = cfg_data[0];
                    CFG_HIGH_NIBBLE_FIRST: regs_shadow.high_nibble_first = cfg_data[0];
                    CFG_START_HISTORY:     regs_shadow.start_history     = cfg_data;
                    CFG_START_STEP:        regs_shadow.start_step        = cfg_data[14:0];
                    default: ;
                endcase
            end

            // byte beat: reload on restart, then two nibble decodes
            if (in_valid && in_ready)
            begin
                if (in_data.restart)
                begin
                    chan_history[0] = regs_shadow.start_history;
                    chan_history[1] = regs_shadow.start_history;
                    chan_step[0]    = limit_step(int'(regs_shadow.start_step));
                    chan_step[1]    = limit_step(int'(regs_shadow.start_step));
                end
                if (regs_shadow.high_nibble_first)
                begin
                    code_a = in_data.data_byte[7:4];
                    code_b = in_data.data_byte[3:0];
                end
                else
                begin
                    code_a = in_data.data_byte[3:0];
                    code_b = in_data.data_byte[7:4];
                end
                first_s.pcm_sample    = decode_code(1'b0, code_a);
                first_s.channel_id    = 1'b0;
                first_s.last_of_pair  = 1'b0;
                second_s.pcm_sample   = decode_code(regs_shadow.stereo_mode, code_b);
                second_s.channel_id   = regs_shadow.stereo_mode;
                second_s.last_of_pair = 1'b1;
                predicted_samples.push_back(first_s);
                predicted_samples.push_back(second_s);
            end
            pending_count = predicted_samples.size();
        end
    end

endmodule

// File: dv/tb_leaky_adpcm_nibble_decoder_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_leaky_adpcm_nibble_decoder_unit
// drives bytes and register settings into the leaky adpcm decoder with
// random gaps and stalls on both channels, including two long output stalls;
// the sample checker beside the block predicts and compares every sample
// ---------------------------------------------------------------------------

module tb_leaky_adpcm_nibble_decoder_unit;

    import ladpcm_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SEGMENTS     = 11;
    localparam int SEG_BYTES    = 50;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 6;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    int mismatch_count;
    int pending_count;
    int out_beats_seen;
    int tx_idle_pct;
    int rx_idle_pct;
    int burst_req;
    int bytes_sent;
    int settings_used;
    int cycle_count;

    leaky_adpcm_nibble_decoder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    adpcm_sample_checker sample_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .out_beats_seen (out_beats_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    // sample receiver: random stalls, or a long hold-off when one is requested
    initial
    begin : receiver
        int burst_seen;
        burst_seen = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (burst_req != burst_seen)
            begin
                burst_seen = burst_req;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // one byte beat, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic r);
        in_beat_t beat;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        beat.data_byte = b;
        beat.restart   = r;
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        bytes_sent++;
    endtask

    // stop offering bytes and wait until every sample is out
    task automatic settle_block();
        in_valid <= 1'b0;
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] word);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [15:0] stereo_w, input logic [15:0] order_w,
                                input logic [15:0] hist_w, input logic [15:0] step_w);
        write_reg(CFG_STEREO_MODE, stereo_w);
        write_reg(CFG_HIGH_NIBBLE_FIRST, order_w);
        write_reg(CFG_START_HISTORY, hist_w);
        write_reg(CFG_START_STEP, step_w);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // mostly random bytes, some with both codes at full or zero magnitude
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        b = 8'($urandom);
        case ($urandom_range(9))
            0:
            begin
                b[2:0] = 3'b111;
                b[6:4] = 3'b111;
            end
            1:
            begin
                b[2:0] = 3'b000;
                b[6:4] = 3'b000;
            end
            default: ;
        endcase
        return b;
    endfunction

    // start step words around both clamp edges, with bit 15 as noise
    function automatic logic [15:0] pick_step_word();
        logic [15:0] w;
        case ($urandom_range(7))
            0:       w = 16'd0;
            1:       w = 16'd126;
            2:       w = 16'd127;
            3:       w = 16'd128;
            4:       w = 16'd24576;
            5:       w = 16'd24577;
            6:       w = 16'd32767;
            default: w = 16'($urandom_range(4000));
        endcase
        w[15] = 1'($urandom);
        return w;
    endfunction

    // stimulus
    initial
    begin : stimulus
        int          ph;
        int          seg;
        int          k;
        logic [15:0] w_stereo;
        logic [15:0] w_order;
        logic [15:0] w_hist;
        logic [15:0] w_step;
        logic        r;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_STEREO_MODE;
        cfg_data      = 16'd0;
        in_valid      = 1'b0;
        in_data       = '0;
        tx_idle_pct   = 19;
        rx_idle_pct   = 60;
        burst_req     = 0;
        bytes_sent    = 0;
        settings_used = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: mono, low nibble first; drive step to max and min
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        repeat (4) send_byte(8'h77, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0);

        // stereo, high nibble first, most negative history, step below range
        settle_block();
        program_regs(16'h0001, 16'h0001, 16'h8000, 16'h0000);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h08, 1'b0);
        send_byte(8'h80, 1'b0);

        // stereo, low nibble first, most positive history, step above range
        settle_block();
        program_regs(16'hFFFF, 16'hFFFE, 16'h7FFF, 16'hFFFF);
        send_byte(8'h77, 1'b1);
        send_byte(8'h77, 1'b0);
        send_byte(8'hF7, 1'b0);

        // mono, high nibble first, restart mid-stream
        settle_block();
        program_regs(16'h0000, 16'h0001, 16'd12345, 16'd24577);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'hC5, 1'b1);

        // random segments, each under its own register setting
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 19;
                    rx_idle_pct = 60;
                end
                1:
                begin
                    tx_idle_pct = 60;
                    rx_idle_pct = 19;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (seg = 0; seg < SEGMENTS; seg++)
            begin
                settle_block();
                w_stereo    = 16'($urandom);
                w_stereo[0] = seg[0];
                w_order     = 16'($urandom);
                w_order[0]  = seg[1];
                if (seg == 0)
                begin
                    w_hist = 16'h8000;
                    w_step = 16'h0000;
                end
                else if (seg == 1)
                begin
                    w_hist = 16'h7FFF;
                    w_step = 16'hFFFF;
                end
                else
                begin
                    w_hist = 16'($urandom);
                    w_step = pick_step_word();
                end
                program_regs(w_stereo, w_order, w_hist, w_step);
                for (k = 0; k < SEG_BYTES; k++)
                begin
                    // long output stall while bytes keep coming
                    if (ph != 1 && seg == 5 && k == 10)
                    begin
                        burst_req <= burst_req + 1;
                    end
                    if (k == 0)
                    begin
                        r = ($urandom_range(9) < 7);
                    end
                    else
                    begin
                        r = ($urandom_range(99) < 8);
                    end
                    send_byte(pick_byte(), r);
                end
            end
        end

        settle_block();
        $display("covered %0d bytes and %0d samples over %0d register settings",
                 bytes_sent, out_beats_seen, settings_used);
        $display("mono and stereo, both nibble orders, restarts, step clamps, long stall");
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ladpcm_pkg.sv
rtl/ladpcm_front.sv
rtl/ladpcm_back.sv
rtl/leaky_adpcm_nibble_decoder_unit.sv
dv/adpcm_sample_checker.sv
dv/tb_leaky_adpcm_nibble_decoder_unit.sv
